[rtl/mixed_radix_index_converter_macros.svh]
// Assertion macros for the mixed-radix index converter
`ifndef MIXED_RADIX_INDEX_CONVERTER_MACROS_SVH
`define MIXED_RADIX_INDEX_CONVERTER_MACROS_SVH
`define MRI_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define MRI_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[rtl/mri_pkg.sv]
// Package: payload types, widths and register indexes for the index converter
`default_nettype none
package mri_pkg;
  localparam int unsigned MaxDimsDef = 4;
  localparam int unsigned SizeBitsDef = 10;
  localparam int unsigned CoordW = 10;
  localparam int unsigned FlatW = 40;
  localparam int unsigned CfgW = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumDims = 4;
  localparam int unsigned DivBitsPerCyc = 5;
  localparam int unsigned StageCycles = FlatW / DivBitsPerCyc;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIMS = 3'd0,
    REG_SIZE0 = 3'd1,
    REG_SIZE1 = 3'd2,
    REG_SIZE2 = 3'd3,
    REG_SIZE3 = 3'd4
  } reg_idx_e;

  typedef enum logic {
    FUNC_FLATTEN = 1'b0,
    FUNC_UNFLATTEN = 1'b1
  } func_e;

  typedef struct packed {
    logic func;
    logic [CoordW-1:0] coord_a;
    logic [CoordW-1:0] coord_b;
    logic [CoordW-1:0] coord_c;
    logic [CoordW-1:0] coord_d;
    logic [FlatW-1:0] flat_in;
  } req_t;

  typedef struct packed {
    logic [FlatW-1:0] flat_out;
    logic [CoordW-1:0] out_a;
    logic [CoordW-1:0] out_b;
    logic [CoordW-1:0] out_c;
    logic [CoordW-1:0] out_d;
    logic range_error;
  } res_t;
endpackage
`default_nettype wire

[rtl/mri_stage.sv]
// One dimension step as a chain of StageCycles registers: multiply-add for flatten, restoring divide for unflatten
`default_nettype none
module mri_stage #(
  parameter int unsigned SizeBits = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  logic func_i,
  input  logic active_i,
  input  logic [SizeBits:0] size_i,
  input  logic [39:0] acc_i,
  input  logic [9:0] coord_i,
  input  logic err_i,
  output logic valid_o,
  output logic func_o,
  output logic [39:0] acc_o,
  output logic [9:0] digit_o,
  output logic err_o
);
  import mri_pkg::*;
  logic valid_q [StageCycles];
  logic func_q [StageCycles];
  logic err_q [StageCycles];
  logic act_q [StageCycles];
  logic [SizeBits:0] size_q [StageCycles];
  logic [39:0] acc_q [StageCycles];
  logic [SizeBits:0] rem_q [StageCycles];
  logic vin [StageCycles];
  logic fin [StageCycles];
  logic ein [StageCycles];
  logic ain [StageCycles];
  logic [SizeBits:0] szin [StageCycles];
  logic [39:0] accin [StageCycles];
  logic [SizeBits:0] remin [StageCycles];
  logic [39:0] acc_d [StageCycles];
  logic [SizeBits:0] rem_d [StageCycles];
  logic [51:0] prod;
  logic [SizeBits+1:0] trial;

  always_comb begin
    vin[0] = valid_i;
    fin[0] = func_i;
    ein[0] = err_i;
    ain[0] = active_i;
    szin[0] = size_i;
    accin[0] = acc_i;
    remin[0] = '0;
    for (int t = 1; t < StageCycles; t++) begin
      vin[t] = valid_q[t-1];
      fin[t] = func_q[t-1];
      ein[t] = err_q[t-1];
      ain[t] = act_q[t-1];
      szin[t] = size_q[t-1];
      accin[t] = acc_q[t-1];
      remin[t] = rem_q[t-1];
    end
  end

  // unflatten shifts the dividend through the remainder DivBitsPerCyc bits per cycle; flatten is a multiply-add
  always_comb begin
    prod = 52'(accin[0]) * 52'(szin[0]);
    trial = '0;
    for (int t = 0; t < StageCycles; t++) begin
      acc_d[t] = accin[t];
      rem_d[t] = remin[t];
      if (ain[t] && fin[t] == FUNC_UNFLATTEN) begin
        for (int b = 0; b < DivBitsPerCyc; b++) begin
          trial = {rem_d[t], acc_d[t][39]};
          acc_d[t] = {acc_d[t][38:0], 1'b0};
          if (trial >= {1'b0, szin[t]}) begin
            trial = trial - {1'b0, szin[t]};
            acc_d[t][0] = 1'b1;
          end
          rem_d[t] = trial[SizeBits:0];
        end
      end
    end
    if (ain[0] && fin[0] == FUNC_FLATTEN) begin
      acc_d[0] = prod[39:0] + {30'd0, coord_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < StageCycles; t++) valid_q[t] <= 1'b0;
    end else begin
      for (int t = 0; t < StageCycles; t++) valid_q[t] <= vin[t];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int t = 0; t < StageCycles; t++) begin
      func_q[t] <= fin[t];
      err_q[t] <= ein[t];
      act_q[t] <= ain[t];
      size_q[t] <= szin[t];
      acc_q[t] <= acc_d[t];
      rem_q[t] <= rem_d[t];
    end
  end

  assign valid_o = valid_q[StageCycles-1];
  assign func_o = func_q[StageCycles-1];
  assign acc_o = acc_q[StageCycles-1];
  assign digit_o = 10'(rem_q[StageCycles-1]);
  assign err_o = err_q[StageCycles-1];
endmodule
`default_nettype wire

[rtl/mixed_radix_index_converter.sv]
// Top level: pipelined column-major index flatten and unflatten over up to four dimensions
// Pipeline: two setup stages, then one mri_stage register chain per dimension step.
// One beat accepted every cycle; busy is always low, so start is taken whenever high.
// The receiver cannot stall; each result shows for one cycle with done_o.
// Reset clears the valid bits and sets dims_q and every size to 1.
`default_nettype none
module mixed_radix_index_converter #(
  parameter int unsigned MaxDims = mri_pkg::MaxDimsDef,
  parameter int unsigned SizeBits = mri_pkg::SizeBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  mri_pkg::req_t req_i,
  output logic done_o,
  output mri_pkg::res_t res_o,
  input  logic cfg_we_i,
  input  logic [mri_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mri_pkg::CfgW-1:0] cfg_data_i
);
  import mri_pkg::*;
  localparam int unsigned Lim = (MaxDims < NumDims) ? MaxDims : NumDims;

  logic [2:0] dims_q;
  logic [CfgW-1:0] size_q [NumDims];
  logic [SizeBits:0] esz [NumDims];
  logic [2:0] n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 3'd1;
      for (int i = 0; i < NumDims; i++) size_q[i] <= CfgW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIMS:  dims_q <= cfg_data_i[2:0];
        REG_SIZE0: size_q[0] <= cfg_data_i;
        REG_SIZE1: size_q[1] <= cfg_data_i;
        REG_SIZE2: size_q[2] <= cfg_data_i;
        REG_SIZE3: size_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    n = dims_q;
    if (n == 3'd0) n = 3'd1;
    if (32'(n) > Lim) n = 3'(Lim);
    for (int i = 0; i < NumDims; i++) begin
      if (32'(size_q[i]) > (32'd1 << SizeBits)) esz[i] = (SizeBits+1)'(1) << SizeBits;
      else esz[i] = (SizeBits+1)'(size_q[i]);
    end
  end

  assign busy = 1'b0;

  // stage 0: range checks and total
  logic [9:0] c [NumDims];
  logic s0_err;
  logic [21:0] tot01, tot23;
  logic [2:0] d3;
  always_comb begin
    c[0] = req_i.coord_a & 10'((1 << SizeBits) - 1);
    c[1] = req_i.coord_b & 10'((1 << SizeBits) - 1);
    c[2] = req_i.coord_c & 10'((1 << SizeBits) - 1);
    c[3] = req_i.coord_d & 10'((1 << SizeBits) - 1);
    s0_err = 1'b0;
    for (int i = 0; i < NumDims; i++)
      if (3'(i) < n && {1'b0, c[i]} >= 11'(esz[i])) s0_err = 1'b1;
    tot01 = 22'(esz[0]) * (n > 3'd1 ? 22'(esz[1]) : 22'd1);
    tot23 = (n > 3'd2 ? 22'(esz[2]) : 22'd1) * (n > 3'd3 ? 22'(esz[3]) : 22'd1);
    d3 = n - 3'd1;
  end

  logic v0_q, f0_q, e0_q;
  logic [21:0] t01_q, t23_q;
  logic [39:0] k0_q;
  logic [9:0] c0_q [NumDims];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else v0_q <= start;
  end
  always_ff @(posedge clk_i) begin
    f0_q <= req_i.func;
    e0_q <= s0_err;
    t01_q <= tot01;
    t23_q <= tot23;
    k0_q <= req_i.flat_in;
    c0_q <= c;
  end

  // stage 1: unflatten bound check, Horner seed
  logic [43:0] tot;
  logic e1;
  logic [39:0] seed;
  always_comb begin
    tot = 44'(t01_q) * 44'(t23_q);
    e1 = (f0_q == FUNC_FLATTEN) ? e0_q : ({4'd0, k0_q} >= tot);
    seed = (f0_q == FUNC_FLATTEN) ? 40'(c0_q[d3[1:0]]) : k0_q;
  end

  logic v1, f1;
  logic [39:0] a1;
  logic [9:0] c1 [NumDims];
  logic x1;
  logic v1_q, f1_q, e1_q;
  logic [39:0] a1_q;
  logic [9:0] cc_q [NumDims];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    f1_q <= f0_q;
    e1_q <= e1;
    a1_q <= seed;
    cc_q <= c0_q;
  end
  assign v1 = v1_q;
  assign f1 = f1_q;
  assign a1 = a1_q;
  assign c1 = cc_q;
  assign x1 = e1_q;

  // dimension steps: one mri_stage per dimension, StageCycles registers deep
  logic vs [NumDims+1];
  logic fs [NumDims+1];
  logic es [NumDims+1];
  logic [39:0] as_ [NumDims+1];
  logic [9:0] dg [NumDims];
  logic [9:0] cp [NumDims+1][NumDims];
  logic [9:0] dp [NumDims+1][NumDims];
  assign vs[0] = v1;
  assign fs[0] = f1;
  assign es[0] = x1;
  assign as_[0] = a1;
  assign cp[0] = c1;
  for (genvar j = 0; j < NumDims; j++) begin : g_dp0
    assign dp[0][j] = '0;
  end

  for (genvar s = 0; s < NumDims; s++) begin : g_st
    // flatten step s uses dimension d3-1-s; unflatten step s uses dimension s
    logic [2:0] fd;
    logic act;
    logic [SizeBits:0] sz;
    logic [9:0] cf;
    logic [9:0] cq [StageCycles][NumDims];
    logic [9:0] dq [StageCycles][NumDims];
    always_comb begin
      fd = d3 - 3'(s) - 3'd1;
      if (fs[s] == FUNC_FLATTEN) begin
        act = (3'(s) < d3);
        sz = esz[fd[1:0]];
        cf = cp[s][fd[1:0]];
      end else begin
        act = (3'(s) < n);
        sz = esz[s];
        cf = '0;
      end
    end
    mri_stage #(.SizeBits(SizeBits)) u_stage (
      .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(vs[s]), .func_i(fs[s]),
      .active_i(act && !es[s]), .size_i(sz),
      .acc_i(as_[s]), .coord_i(cf), .err_i(es[s]),
      .valid_o(vs[s+1]), .func_o(fs[s+1]), .acc_o(as_[s+1]), .digit_o(dg[s]),
      .err_o(es[s+1])
    );
    always_ff @(posedge clk_i) begin
      cq[0] <= cp[s];
      dq[0] <= dp[s];
      for (int t = 1; t < StageCycles; t++) begin
        cq[t] <= cq[t-1];
        dq[t] <= dq[t-1];
      end
    end
    assign cp[s+1] = cq[StageCycles-1];
    for (genvar j = 0; j < NumDims; j++) begin : g_dig
      assign dp[s+1][j] = (j == s) ? dg[s] : dq[StageCycles-1][j];
    end
  end

  logic ok;
  assign ok = !es[NumDims];
  always_comb begin
    done_o = vs[NumDims];
    res_o = '0;
    res_o.range_error = es[NumDims];
    if (ok) begin
      if (fs[NumDims] == FUNC_FLATTEN) res_o.flat_out = as_[NumDims];
      else begin
        res_o.out_a = dp[NumDims][0];
        res_o.out_b = dp[NumDims][1];
        res_o.out_c = dp[NumDims][2];
        res_o.out_d = dp[NumDims][3];
      end
    end
  end
endmodule
`default_nettype wire

[rtl/mri_checker.sv]
// Port checker for the index converter, bound to the top level
`default_nettype none
`include "mixed_radix_index_converter_macros.svh"
module mri_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic done_o,
  input mri_pkg::res_t res_o
);
  logic err_beat, flat_beat, res_clear, coords_clear;
  assign err_beat = done_o && res_o.range_error;
  assign flat_beat = done_o && (res_o.flat_out != '0);
  assign res_clear = (res_o.flat_out == '0) && (res_o.out_a == '0);
  assign coords_clear = (res_o.out_a == '0) && (res_o.out_d == '0);
  `MRI_ASSERT_IMP(a_busy_low, clk_i, rst_ni, 1'b1, !busy, "busy raised")
  `MRI_ASSERT_IMP(a_err_zero, clk_i, rst_ni, err_beat, res_clear, "error beat not zero")
  `MRI_ASSERT_IMP(a_one_kind, clk_i, rst_ni, flat_beat, coords_clear, "mixed result")
endmodule
bind mixed_radix_index_converter mri_checker u_mri_checker (.*);
`default_nettype wire

[sim/tb_mixed_radix_index_converter.sv]
// Testbench: mixed-radix index converter checked against an in-bench predictor
`default_nettype none
module tb_mixed_radix_index_converter;
  import mri_pkg::*;

  localparam int unsigned Latency = 2 + NumDims * StageCycles;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  res_t res_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  logic [2:0] dims_cfg;
  logic [CfgW-1:0] size_cfg [NumDims];

  res_t expected_q [$];
  int unsigned mismatches;
  bit orphan_seen;
  bit calm;

  mixed_radix_index_converter u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .done_o(done_o),
    .res_o(res_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned used_dims();
    int unsigned n;
    n = 32'(dims_cfg);
    if (n < 1) n = 1;
    if (n > NumDims) n = NumDims;
    return n;
  endfunction

  function automatic logic [63:0] dim_size(int unsigned d);
    logic [63:0] s;
    s = 64'(size_cfg[d]);
    return (s > 64'd1024) ? 64'd1024 : s;
  endfunction

  function automatic res_t convert_index(req_t rq);
    res_t r;
    int unsigned n;
    logic [63:0] c [NumDims];
    logic [63:0] acc;
    logic [63:0] k;
    logic [63:0] total;
    logic [CoordW-1:0] o [NumDims];
    r = '0;
    n = used_dims();
    c[0] = 64'(rq.coord_a);
    c[1] = 64'(rq.coord_b);
    c[2] = 64'(rq.coord_c);
    c[3] = 64'(rq.coord_d);
    for (int d = 0; d < NumDims; d++) o[d] = '0;
    if (rq.func == FUNC_FLATTEN) begin
      for (int d = 0; d < n; d++) if (c[d] >= dim_size(d)) r.range_error = 1'b1;
      if (!r.range_error) begin
        acc = c[n-1];
        for (int d = n - 1; d > 0; d--) acc = acc * dim_size(d - 1) + c[d-1];
        r.flat_out = acc[FlatW-1:0];
      end
    end else begin
      k = 64'(rq.flat_in);
      total = 64'd1;
      for (int d = 0; d < n; d++) total = total * dim_size(d);
      if (k >= total) begin
        r.range_error = 1'b1;
      end else begin
        for (int d = 0; d < n; d++) begin
          o[d] = CoordW'(k % dim_size(d));
          k = k / dim_size(d);
        end
      end
    end
    r.out_a = o[0];
    r.out_b = o[1];
    r.out_c = o[2];
    r.out_d = o[3];
    return r;
  endfunction

  task automatic drain_results();
    start = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    if (idx == REG_DIMS) dims_cfg = value[2:0];
    else size_cfg[idx - 1] = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_grid(logic [CfgW-1:0] dims, logic [CfgW-1:0] s0, logic [CfgW-1:0] s1,
                          logic [CfgW-1:0] s2, logic [CfgW-1:0] s3);
    drain_results();
    write_reg(REG_DIMS, dims);
    write_reg(REG_SIZE0, s0);
    write_reg(REG_SIZE1, s1);
    write_reg(REG_SIZE2, s2);
    write_reg(REG_SIZE3, s3);
  endtask

  // Called at a falling edge; returns at a falling edge after the beat is taken.
  task automatic send_beat(req_t rq);
    start = 1'b1;
    req_i = rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(convert_index(rq));
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  function automatic req_t rand_req();
    req_t rq;
    rq = '0;
    rq.func = func_e'($urandom_range(0, 1));
    rq.coord_a = CoordW'($urandom);
    rq.coord_b = CoordW'($urandom);
    rq.coord_c = CoordW'($urandom);
    rq.coord_d = CoordW'($urandom);
    rq.flat_in = FlatW'({$urandom, $urandom});
    return rq;
  endfunction

  // Mostly in-grid requests; the rest raw noise.
  function automatic req_t grid_req();
    req_t rq;
    logic [63:0] total;
    rq = rand_req();
    if ($urandom_range(0, 4) != 0) begin
      rq.coord_a = (size_cfg[0] == 0) ? '0 : CoordW'($urandom_range(0, 32'(dim_size(0) - 1)));
      rq.coord_b = (size_cfg[1] == 0) ? '0 : CoordW'($urandom_range(0, 32'(dim_size(1) - 1)));
      rq.coord_c = (size_cfg[2] == 0) ? '0 : CoordW'($urandom_range(0, 32'(dim_size(2) - 1)));
      rq.coord_d = (size_cfg[3] == 0) ? '0 : CoordW'($urandom_range(0, 32'(dim_size(3) - 1)));
      total = 64'd1;
      for (int d = 0; d < used_dims(); d++) total = total * dim_size(d);
      rq.flat_in = (total == 0) ? FlatW'({$urandom, $urandom}) :
                   FlatW'({$urandom, $urandom} % (total + 64'd1));
    end
    return rq;
  endfunction

  task automatic test_reset_grid();
    req_t rq;
    rq = '0;
    send_beat(rq);
    rq.func = FUNC_UNFLATTEN;
    send_beat(rq);
    rq.flat_in = 1;
    send_beat(rq);
  endtask

  task automatic test_directed_extremes();
    req_t rq;
    set_grid(4, 1024, 1024, 1024, 1024);
    rq = '0;
    rq.coord_a = '1; rq.coord_b = '1; rq.coord_c = '1; rq.coord_d = '1;
    send_beat(rq);
    rq.func = FUNC_UNFLATTEN;
    rq.flat_in = '1;
    send_beat(rq);
    rq.flat_in = 40'hFF_FFFF_FFFF;
    send_beat(rq);
    set_grid(0, 2047, 5, 3, 7);
    rq = '0;
    rq.coord_a = 1023; rq.coord_b = 1023;
    send_beat(rq);
    rq.func = FUNC_UNFLATTEN; rq.flat_in = 1023;
    send_beat(rq);
    rq.flat_in = 1024;
    send_beat(rq);
    set_grid(7, 3, 0, 5, 2);
    rq = '0;
    send_beat(rq);
    rq.func = FUNC_UNFLATTEN;
    send_beat(rq);
    set_grid(3, 7, 5, 3, 0);
    rq = '0;
    rq.coord_a = 6; rq.coord_b = 4; rq.coord_c = 2; rq.coord_d = 1023;
    send_beat(rq);
    rq.coord_b = 5;
    send_beat(rq);
    rq = '0; rq.func = FUNC_UNFLATTEN; rq.flat_in = 104;
    send_beat(rq);
    rq.flat_in = 105;
    send_beat(rq);
  endtask

  task automatic test_random_grids();
    logic [CfgW-1:0] sz [NumDims];
    for (int phase = 0; phase < 14; phase++) begin
      for (int d = 0; d < NumDims; d++) begin
        case ($urandom_range(0, 5))
          0: sz[d] = CfgW'($urandom);
          1: sz[d] = 1024;
          2: sz[d] = CfgW'($urandom_range(0, 2));
          default: sz[d] = CfgW'($urandom_range(1, 40));
        endcase
      end
      set_grid(CfgW'($urandom_range(0, 7)), sz[0], sz[1], sz[2], sz[3]);
      if (phase == 12) calm = 1'b1;
      for (int i = 0; i < 60; i++) send_beat(grid_req());
      start = 1'b0;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_DIMS;
    cfg_data_i = '0;
    dims_cfg = 3'd1;
    for (int d = 0; d < NumDims; d++) size_cfg[d] = 1;
    mismatches = 0;
    orphan_seen = 1'b0;
    calm = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_grid();
    test_directed_extremes();
    test_random_grids();
    start = 1'b0;
    drain_results();
    if (mismatches == 0 && !orphan_seen && expected_q.size() == 0) begin
      $display("tb_mixed_radix_index_converter: done, clean");
    end else begin
      $display("tb_mixed_radix_index_converter: done, errors");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        orphan_seen = 1'b1;
        if (mismatches < 10) $display("unexpected result beat %h", res_o);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (res_o.flat_out !== want.flat_out || res_o.out_a !== want.out_a ||
            res_o.out_b !== want.out_b || res_o.out_c !== want.out_c ||
            res_o.out_d !== want.out_d || res_o.range_error !== want.range_error) begin
          if (mismatches < 10)
            $display("mismatch: expected %h got %h", want, res_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #400000;
    $display("tb_mixed_radix_index_converter: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
